// ===== src/vector3_arithmetic_unit_defines.svh =====
// assertion macros for the vector unit
`ifndef VECTOR3_ARITHMETIC_UNIT_DEFINES_SVH
`define VECTOR3_ARITHMETIC_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define VAU_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	prop) else $error("vau assertion failed");
`define VAU_ASSERT_IMPL(lbl, ante, cons) `VAU_ASSERT(lbl, (ante) |-> (cons))
`else
`define VAU_ASSERT(lbl, prop)
`define VAU_ASSERT_IMPL(lbl, ante, cons)
`endif

`endif

// ===== src/vau_pkg.sv =====
`default_nettype none
package vau_pkg;
	localparam logic [2:0] OP_ADD   = 3'd0;
	localparam logic [2:0] OP_SUB   = 3'd1;
	localparam logic [2:0] OP_DOT   = 3'd2;
	localparam logic [2:0] OP_CROSS = 3'd3;
	localparam logic [2:0] OP_LEN   = 3'd4;
	localparam logic [2:0] OP_UNIT  = 3'd5;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_OVF  = 2'd1;
	localparam logic [1:0] ST_ZERO = 2'd2;

	typedef struct packed {
		logic [2:0] op;
		logic [2:0] neg;
		logic [1:0] st;
	} ctl_t;

	typedef struct packed {
		logic [31:0] s;
		logic [31:0] z;
		logic [31:0] y;
		logic [31:0] x;
	} res_t;
endpackage
`default_nettype wire

// ===== src/vau_mul.sv =====
`default_nettype none
module vau_mul #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [2:0]         op,
	input  wire logic [31:0]        ax,
	input  wire logic [31:0]        ay,
	input  wire logic [31:0]        az,
	input  wire logic [31:0]        bx,
	input  wire logic [31:0]        by,
	input  wire logic [31:0]        bz,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output vau_pkg::ctl_t           out_ctl,
	output vau_pkg::res_t           out_res,
	output logic [W-1:0]            out_mx,
	output logic [W-1:0]            out_my,
	output logic [W-1:0]            out_mz,
	output logic [2*W-1:0]          out_ss
);
	localparam logic signed [2*W+1:0] SMAX = {{(W+3){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [2*W+1:0] SMIN = ~SMAX;
	localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

	function automatic logic [W-1:0] take_in(input logic [31:0] v);
		logic [W+31:0] t;
		t = {{W{1'b0}}, v};
		return t[W-1:0];
	endfunction

	function automatic logic [31:0] to32(input logic [W-1:0] v);
		logic [W+31:0] t;
		t = {32'b0, v};
		return t[31:0];
	endfunction

	// {overflow, saturated word}
	function automatic logic [W:0] sat_w(input logic signed [2*W+1:0] v);
		if (v > SMAX) begin
			return {1'b1, WMAX};
		end else if (v < SMIN) begin
			return {1'b1, WMIN};
		end else begin
			return {1'b0, v[W-1:0]};
		end
	endfunction

	logic v_s1, v_s2, v_s3;
	logic r1, r2, r3;
	logic [2:0] op_s1, op_s2;
	logic [W-1:0] a_s1 [3];
	logic [W-1:0] b_s1 [3];

	assign r3 = !v_s3 || out_ready;
	assign r2 = !v_s2 || r3;
	assign r1 = !v_s1 || r2;
	assign in_ready = r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (r1) v_s1 <= in_valid;
			if (r2) v_s2 <= v_s1;
			if (r3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (r1) begin
			op_s1   <= op;
			a_s1[0] <= take_in(ax);
			a_s1[1] <= take_in(ay);
			a_s1[2] <= take_in(az);
			b_s1[0] <= take_in(bx);
			b_s1[1] <= take_in(by);
			b_s1[2] <= take_in(bz);
		end
	end

	// stage 2: operand selection, products, add and subtract
	logic signed [W-1:0] ma [3];
	logic signed [W-1:0] mb [3];
	logic [W:0] add_sum [3];
	logic [W-1:0] mag [3];
	logic sub;

	always_comb begin
		unique case (op_s1)
			vau_pkg::OP_CROSS: begin
				ma[0] = a_s1[1]; mb[0] = b_s1[2];
				ma[1] = a_s1[2]; mb[1] = b_s1[1];
				ma[2] = a_s1[2]; mb[2] = b_s1[0];
			end
			vau_pkg::OP_LEN, vau_pkg::OP_UNIT: begin
				ma[0] = a_s1[0]; mb[0] = a_s1[0];
				ma[1] = a_s1[1]; mb[1] = a_s1[1];
				ma[2] = a_s1[2]; mb[2] = a_s1[2];
			end
			default: begin
				ma[0] = a_s1[0]; mb[0] = b_s1[0];
				ma[1] = a_s1[1]; mb[1] = b_s1[1];
				ma[2] = a_s1[2]; mb[2] = b_s1[2];
			end
		endcase
	end

	assign sub = (op_s1 == vau_pkg::OP_SUB);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			add_sum[i] = {a_s1[i][W-1], a_s1[i]} +
				(sub ? -{b_s1[i][W-1], b_s1[i]} : {b_s1[i][W-1], b_s1[i]});
			mag[i] = a_s1[i][W-1] ? -a_s1[i] : a_s1[i];
		end
	end

	logic signed [2*W-1:0] p_s2 [6];
	logic [W-1:0] add_s2 [3];
	logic [2:0] aov_s2;
	logic [W-1:0] mag_s2 [3];
	logic [2:0] neg_s2;

	always_ff @(posedge clk) begin
		if (r2) begin
			op_s2   <= op_s1;
			p_s2[0] <= ma[0] * mb[0];
			p_s2[1] <= ma[1] * mb[1];
			p_s2[2] <= ma[2] * mb[2];
			p_s2[3] <= $signed(a_s1[0]) * $signed(b_s1[2]);
			p_s2[4] <= $signed(a_s1[0]) * $signed(b_s1[1]);
			p_s2[5] <= $signed(a_s1[1]) * $signed(b_s1[0]);
			for (int i = 0; i < 3; i++) begin
				aov_s2[i] <= add_sum[i][W] != add_sum[i][W-1];
				add_s2[i] <= (add_sum[i][W] != add_sum[i][W-1]) ?
					(add_sum[i][W] ? WMIN : WMAX) : add_sum[i][W-1:0];
				mag_s2[i] <= mag[i];
				neg_s2[i] <= a_s1[i][W-1];
			end
		end
	end

	// stage 3: sums, scaling and saturation
	logic signed [2*W+1:0] dsum, cx, cy, cz;
	logic [W:0] sd, sx, sy, sz;
	vau_pkg::ctl_t ctl_n;
	vau_pkg::res_t res_n;

	assign dsum = p_s2[0] + p_s2[1] + p_s2[2];
	assign cx = p_s2[0] - p_s2[1];
	assign cy = p_s2[2] - p_s2[3];
	assign cz = p_s2[4] - p_s2[5];
	assign sd = sat_w(dsum >>> F);
	assign sx = sat_w(cx >>> F);
	assign sy = sat_w(cy >>> F);
	assign sz = sat_w(cz >>> F);

	always_comb begin
		res_n = '0;
		ctl_n.op = op_s2;
		ctl_n.neg = neg_s2;
		ctl_n.st = vau_pkg::ST_OK;
		unique case (op_s2)
			vau_pkg::OP_ADD, vau_pkg::OP_SUB: begin
				res_n.x = to32(add_s2[0]);
				res_n.y = to32(add_s2[1]);
				res_n.z = to32(add_s2[2]);
				if (|aov_s2) ctl_n.st = vau_pkg::ST_OVF;
			end
			vau_pkg::OP_DOT: begin
				res_n.s = to32(sd[W-1:0]);
				if (sd[W]) ctl_n.st = vau_pkg::ST_OVF;
			end
			vau_pkg::OP_CROSS: begin
				res_n.x = to32(sx[W-1:0]);
				res_n.y = to32(sy[W-1:0]);
				res_n.z = to32(sz[W-1:0]);
				if (sx[W] || sy[W] || sz[W]) ctl_n.st = vau_pkg::ST_OVF;
			end
			default: begin
				res_n = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (r3) begin
			out_ctl <= ctl_n;
			out_res <= res_n;
			out_mx  <= mag_s2[0];
			out_my  <= mag_s2[1];
			out_mz  <= mag_s2[2];
			out_ss  <= dsum[2*W-1:0];
		end
	end

	assign out_valid = v_s3;
endmodule
`default_nettype wire

// ===== src/vau_sqrt.sv =====
`default_nettype none
module vau_sqrt #(
	parameter int W = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire vau_pkg::ctl_t      in_ctl,
	input  wire vau_pkg::res_t      in_res,
	input  wire logic [W-1:0]       in_mx,
	input  wire logic [W-1:0]       in_my,
	input  wire logic [W-1:0]       in_mz,
	input  wire logic [2*W-1:0]     in_ss,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output vau_pkg::ctl_t           out_ctl,
	output vau_pkg::res_t           out_res,
	output logic [W-1:0]            out_mx,
	output logic [W-1:0]            out_my,
	output logic [W-1:0]            out_mz,
	output logic [W-1:0]            out_len
);
	// one root bit per stage, two radicand bits brought down each time
	logic v_s [W];
	logic rdy [W+1];
	vau_pkg::ctl_t ctl_s [W];
	vau_pkg::res_t res_s [W];
	logic [W-1:0] mx_s [W], my_s [W], mz_s [W];
	logic [W+1:0] rem_s [W];
	logic [W-1:0] root_s [W];
	logic [2*W-1:0] ss_s [W];

	logic src_v [W];
	vau_pkg::ctl_t src_ctl [W];
	vau_pkg::res_t src_res [W];
	logic [W-1:0] src_mx [W], src_my [W], src_mz [W];
	logic [W+1:0] src_rem [W];
	logic [W-1:0] src_root [W];
	logic [2*W-1:0] src_ss [W];
	logic [W+1:0] cur [W];
	logic [W+1:0] trial [W];
	logic ge [W];

	always_comb begin
		rdy[W] = out_ready;
		for (int k = W - 1; k >= 0; k--) begin
			rdy[k] = !v_s[k] || rdy[k+1];
		end
	end
	assign in_ready = rdy[0];

	always_comb begin
		for (int k = 0; k < W; k++) begin
			if (k == 0) begin
				src_v[k] = in_valid;
				src_ctl[k] = in_ctl;
				src_res[k] = in_res;
				src_mx[k] = in_mx;
				src_my[k] = in_my;
				src_mz[k] = in_mz;
				src_rem[k] = '0;
				src_root[k] = '0;
				src_ss[k] = in_ss;
			end else begin
				src_v[k] = v_s[k-1];
				src_ctl[k] = ctl_s[k-1];
				src_res[k] = res_s[k-1];
				src_mx[k] = mx_s[k-1];
				src_my[k] = my_s[k-1];
				src_mz[k] = mz_s[k-1];
				src_rem[k] = rem_s[k-1];
				src_root[k] = root_s[k-1];
				src_ss[k] = ss_s[k-1];
			end
			cur[k] = {src_rem[k][W-1:0], src_ss[k][2*W-1:2*W-2]};
			trial[k] = {src_root[k], 2'b01};
			ge[k] = cur[k] >= trial[k];
		end
	end

	for (genvar k = 0; k < W; k++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				v_s[k] <= src_v[k];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k]) begin
				ctl_s[k]  <= src_ctl[k];
				res_s[k]  <= src_res[k];
				mx_s[k]   <= src_mx[k];
				my_s[k]   <= src_my[k];
				mz_s[k]   <= src_mz[k];
				rem_s[k]  <= ge[k] ? cur[k] - trial[k] : cur[k];
				root_s[k] <= {src_root[k][W-2:0], ge[k]};
				ss_s[k]   <= src_ss[k] << 2;
			end
		end
	end

	assign out_valid = v_s[W-1];
	assign out_ctl = ctl_s[W-1];
	assign out_res = res_s[W-1];
	assign out_mx = mx_s[W-1];
	assign out_my = my_s[W-1];
	assign out_mz = mz_s[W-1];
	assign out_len = root_s[W-1];
endmodule
`default_nettype wire

// ===== src/vau_div.sv =====
`default_nettype none
module vau_div #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire vau_pkg::ctl_t      in_ctl,
	input  wire vau_pkg::res_t      in_res,
	input  wire logic [W-1:0]       in_mx,
	input  wire logic [W-1:0]       in_my,
	input  wire logic [W-1:0]       in_mz,
	input  wire logic [W-1:0]       in_len,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output vau_pkg::ctl_t           out_ctl,
	output vau_pkg::res_t           out_res,
	output logic [F:0]              out_qx,
	output logic [F:0]              out_qy,
	output logic [F:0]              out_qz
);
	localparam int N = F + 1;
	localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};

	function automatic logic [31:0] to32(input logic [W-1:0] v);
		logic [W+31:0] t;
		t = {32'b0, v};
		return t[31:0];
	endfunction

	// length result and zero-length flag settle on entry
	vau_pkg::ctl_t fix_ctl;
	vau_pkg::res_t fix_res;

	always_comb begin
		fix_ctl = in_ctl;
		fix_res = in_res;
		if (in_ctl.op == vau_pkg::OP_LEN) begin
			fix_res.s = to32(in_len[W-1] ? WMAX : in_len);
			if (in_len[W-1]) fix_ctl.st = vau_pkg::ST_OVF;
		end
		if (in_ctl.op == vau_pkg::OP_UNIT && in_len == '0) begin
			fix_ctl.st = vau_pkg::ST_ZERO;
		end
	end

	// restoring division, one quotient bit per stage, three lanes
	logic v_s [N];
	logic rdy [N+1];
	vau_pkg::ctl_t ctl_s [N];
	vau_pkg::res_t res_s [N];
	logic [W-1:0] d_s [N];
	logic [W:0] rem_s [N][3];
	logic [F:0] quot_s [N][3];

	logic src_v [N];
	vau_pkg::ctl_t src_ctl [N];
	vau_pkg::res_t src_res [N];
	logic [W-1:0] src_d [N];
	logic [W:0] src_rem [N][3];
	logic [F:0] src_quot [N][3];
	logic ge [N][3];
	logic [W:0] nrem [N][3];

	always_comb begin
		rdy[N] = out_ready;
		for (int k = N - 1; k >= 0; k--) begin
			rdy[k] = !v_s[k] || rdy[k+1];
		end
	end
	assign in_ready = rdy[0];

	always_comb begin
		for (int k = 0; k < N; k++) begin
			if (k == 0) begin
				src_v[k] = in_valid;
				src_ctl[k] = fix_ctl;
				src_res[k] = fix_res;
				src_d[k] = in_len;
				src_rem[k][0] = {1'b0, in_mx};
				src_rem[k][1] = {1'b0, in_my};
				src_rem[k][2] = {1'b0, in_mz};
				for (int j = 0; j < 3; j++) src_quot[k][j] = '0;
			end else begin
				src_v[k] = v_s[k-1];
				src_ctl[k] = ctl_s[k-1];
				src_res[k] = res_s[k-1];
				src_d[k] = d_s[k-1];
				for (int j = 0; j < 3; j++) begin
					src_rem[k][j] = rem_s[k-1][j];
					src_quot[k][j] = quot_s[k-1][j];
				end
			end
			for (int j = 0; j < 3; j++) begin
				ge[k][j] = src_rem[k][j] >= {1'b0, src_d[k]};
				nrem[k][j] = (ge[k][j] ? src_rem[k][j] - {1'b0, src_d[k]} :
					src_rem[k][j]) << 1;
			end
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				v_s[k] <= src_v[k];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k]) begin
				ctl_s[k] <= src_ctl[k];
				res_s[k] <= src_res[k];
				d_s[k]   <= src_d[k];
				for (int j = 0; j < 3; j++) begin
					rem_s[k][j]  <= nrem[k][j];
					quot_s[k][j] <= {src_quot[k][j][F-1:0], ge[k][j]};
				end
			end
		end
	end

	assign out_valid = v_s[N-1];
	assign out_ctl = ctl_s[N-1];
	assign out_res = res_s[N-1];
	assign out_qx = quot_s[N-1][0];
	assign out_qy = quot_s[N-1][1];
	assign out_qz = quot_s[N-1][2];
endmodule
`default_nettype wire

// ===== src/vector3_arithmetic_unit.sv =====
// pipeline: three product/sum stages, one square root stage per root bit,
// one divider stage per quotient bit, one output stage
// throughput: one word per cycle; a stalled output holds the pipe, bubbles are squeezed out
// reset: arst_n clears every valid bit at once; data registers are not reset
`default_nettype none
`include "vector3_arithmetic_unit_defines.svh"
module vector3_arithmetic_unit #(
	parameter int FRAC_BITS = 16,
	parameter int WORD_BITS = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// a_x, a_y, a_z, b_x, b_y, b_z from bit 0 up
	input  wire logic [191:0] s_axis_tdata,
	// opcode
	input  wire logic [2:0]   s_axis_tuser,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// res_x, res_y, res_z, res_scalar from bit 0 up
	output logic [127:0]      m_axis_tdata,
	// status
	output logic [1:0]        m_axis_tuser
);
	localparam int W = WORD_BITS;
	localparam int F = FRAC_BITS;
	localparam int QW = ((F + 1 > W) ? F + 1 : W) + 1;
	localparam logic [QW-1:0] QMAX = {{(QW-W+1){1'b0}}, {(W-1){1'b1}}};

	function automatic logic [31:0] to32(input logic [W-1:0] v);
		logic [W+31:0] t;
		t = {32'b0, v};
		return t[31:0];
	endfunction

	// {overflow, signed word} for a quotient with its sign applied
	function automatic logic [W:0] unit_fix(input logic [F:0] q, input logic neg);
		logic [QW-1:0] qe;
		logic [QW-1:0] qn;
		qe = {{(QW-F-1){1'b0}}, q};
		qn = -qe;
		if (!neg) begin
			return (qe > QMAX) ? {1'b1, 1'b0, {(W-1){1'b1}}} : {1'b0, qe[W-1:0]};
		end else begin
			return (qe > QMAX + 1'b1) ? {1'b1, 1'b1, {(W-1){1'b0}}} : {1'b0, qn[W-1:0]};
		end
	endfunction

	logic mul_v, mul_r, sq_v, sq_r, dv_v, dv_r;
	vau_pkg::ctl_t mul_ctl, sq_ctl, dv_ctl;
	vau_pkg::res_t mul_res, sq_res, dv_res;
	logic [W-1:0] mul_mx, mul_my, mul_mz, sq_mx, sq_my, sq_mz, sq_len;
	logic [2*W-1:0] mul_ss;
	logic [F:0] qx, qy, qz;

	vau_mul #(.W(W), .F(F)) u_mul (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.op(s_axis_tuser),
		.ax(s_axis_tdata[31:0]), .ay(s_axis_tdata[63:32]), .az(s_axis_tdata[95:64]),
		.bx(s_axis_tdata[127:96]), .by(s_axis_tdata[159:128]), .bz(s_axis_tdata[191:160]),
		.out_valid(mul_v), .out_ready(mul_r),
		.out_ctl(mul_ctl), .out_res(mul_res),
		.out_mx(mul_mx), .out_my(mul_my), .out_mz(mul_mz), .out_ss(mul_ss)
	);

	vau_sqrt #(.W(W)) u_sqrt (
		.clk(clk), .arst_n(arst_n),
		.in_valid(mul_v), .in_ready(mul_r),
		.in_ctl(mul_ctl), .in_res(mul_res),
		.in_mx(mul_mx), .in_my(mul_my), .in_mz(mul_mz), .in_ss(mul_ss),
		.out_valid(sq_v), .out_ready(sq_r),
		.out_ctl(sq_ctl), .out_res(sq_res),
		.out_mx(sq_mx), .out_my(sq_my), .out_mz(sq_mz), .out_len(sq_len)
	);

	vau_div #(.W(W), .F(F)) u_div (
		.clk(clk), .arst_n(arst_n),
		.in_valid(sq_v), .in_ready(sq_r),
		.in_ctl(sq_ctl), .in_res(sq_res),
		.in_mx(sq_mx), .in_my(sq_my), .in_mz(sq_mz), .in_len(sq_len),
		.out_valid(dv_v), .out_ready(dv_r),
		.out_ctl(dv_ctl), .out_res(dv_res),
		.out_qx(qx), .out_qy(qy), .out_qz(qz)
	);

	logic [W:0] ux, uy, uz;
	vau_pkg::res_t fin_res;
	logic [1:0] fin_st;

	assign ux = unit_fix(qx, dv_ctl.neg[0]);
	assign uy = unit_fix(qy, dv_ctl.neg[1]);
	assign uz = unit_fix(qz, dv_ctl.neg[2]);

	always_comb begin
		fin_res = dv_res;
		fin_st = dv_ctl.st;
		if (dv_ctl.op == vau_pkg::OP_UNIT && dv_ctl.st != vau_pkg::ST_ZERO) begin
			fin_res.x = to32(ux[W-1:0]);
			fin_res.y = to32(uy[W-1:0]);
			fin_res.z = to32(uz[W-1:0]);
			fin_st = (ux[W] || uy[W] || uz[W]) ? vau_pkg::ST_OVF : vau_pkg::ST_OK;
		end
	end

	// output word register
	logic valid_q;
	vau_pkg::res_t res_q;
	logic [1:0] stat_q;
	logic [2:0] op_q;

	assign dv_r = !valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (dv_r) begin
			valid_q <= dv_v;
		end
	end

	always_ff @(posedge clk) begin
		if (dv_r) begin
			res_q  <= fin_res;
			stat_q <= fin_st;
			op_q   <= dv_ctl.op;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata = res_q;
	assign m_axis_tuser = stat_q;

	`VAU_ASSERT_IMPL(a_zero_len_clear, valid_q && stat_q == vau_pkg::ST_ZERO, res_q == '0)
	`VAU_ASSERT_IMPL(a_scalar_no_vec, valid_q && (op_q == vau_pkg::OP_DOT || op_q == vau_pkg::OP_LEN), res_q.x == '0 && res_q.y == '0 && res_q.z == '0)
	`VAU_ASSERT_IMPL(a_stall_only_full, !s_axis_tready, m_axis_tvalid && !m_axis_tready)
	`VAU_ASSERT_IMPL(a_status_legal, valid_q, stat_q == vau_pkg::ST_OK || stat_q == vau_pkg::ST_OVF || stat_q == vau_pkg::ST_ZERO)
endmodule
`default_nettype wire
